// ----- sv/ppcm_pkg.sv -----
// Package for the peak-to-peak current meter: configuration register indexes,
// sequencer state codes and fixed field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppcm_pkg;

  // Fixed widths of the configuration and current fields.
  localparam int CFG_W     = 16;
  localparam int FPU_W     = 8;
  localparam int CUR_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Channel count and the index width that addresses them.
  localparam int NCH  = 3;
  localparam int CH_W = 2;

  // The scaled current is multiplied by one thousand before the division.
  localparam int            THOU_W   = 10;
  localparam logic [9:0]    THOUSAND = 10'd1000;

  // Reset values of the configuration registers.
  localparam logic [FPU_W-1:0] FPU_RST   = 8'd10;
  localparam logic [CFG_W-1:0] SCALE_RST = 16'd5;
  localparam logic [CFG_W-1:0] COEFF_RST = 16'd3000;
  localparam logic [CFG_W-1:0] THR_RST   = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAMES_PER_UPDATE = 2'd0,
    CFG_SCALE_NUMERATOR   = 2'd1,
    CFG_COEFF_THOUSANDTHS = 2'd2,
    CFG_ZERO_THRESHOLD    = 2'd3
  } cfg_idx_e;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RAIL  = 9'b000000010,
    S_HI    = 9'b000000100,
    S_LO    = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_SCALE = 9'b000100000,
    S_CUR   = 9'b001000000,
    S_SAT   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_e;

endpackage : ppcm_pkg

`default_nettype wire

// ----- sv/ppcm_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle, shared by all
// divisions of the current meter. Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module ppcm_div #(
  parameter int DW  = 46,
  parameter int DVW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0]  dividend_i,
  input  wire logic [DVW-1:0] divisor_i,
  output logic               done_o,
  output logic [DW-1:0]      quotient_o
);

  localparam int CNT_W = $clog2(DW);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    quo_q;
  logic [DVW-1:0]   rem_q;
  logic [DVW-1:0]   dvs_q;

  logic [DVW:0] shifted;
  logic [DVW:0] diff;
  logic         ge;

  // Bring down the next dividend bit and try to subtract the divisor.
  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = shifted >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DW - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVW-1:0] : shifted[DVW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule : ppcm_div

`default_nettype wire

// ----- sv/peak_to_peak_current_meter_top.sv -----
// Top level of the peak-to-peak current meter: frame tracking, accumulation
// and the sequencer around the shared divider. Uses ppcm_pkg and ppcm_div.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// Sample sets arrive on the input channel (in_valid_i / in_stall_o), one
// request per set, last_in_frame_i marking the final set of a frame. Sets
// that do not end a frame are taken one per cycle and produce no result.
// A set that ends a frame starts the frame-end work on one shared restoring
// divider that yields one quotient bit per cycle; NUM_W = SAMPLE_BITS + 34
// bits, 46 at the defaults. The rail average is always divided; when the
// current update is due, each of the three channels adds two averaging
// divisions, a multiply, a scaling step and, unless the coefficient is zero,
// the current division. While a frame end is being worked on, in_stall_o
// stays high.
// One result request per frame leaves on out_valid_o / out_stall_i. The
// result sits in an output register; a stalled result holds its payload,
// and a following frame end waits for the register to free up before it
// writes it. Configuration writes use cfg_valid_i / cfg_ready_o, always
// ready, and are meant for idle periods only.
// Reset clears the frame tracking, accumulators, held currents and the
// frame counter and loads the register defaults.
module peak_to_peak_current_meter_top
  import ppcm_pkg::*;
#(
  parameter int MAX_FRAME_SAMPLES = 1024,
  parameter int SAMPLE_BITS       = 12
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // Configuration write channel.
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_W-1:0]       cfg_data_i,
  // Sample set channel.
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0] sample_ch1_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_ch2_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_ch3_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_rail_i,
  input  wire logic                   last_in_frame_i,
  // Result channel.
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0]      rail_average_o,
  output logic [CUR_W-1:0]            current_ch1_o,
  output logic [CUR_W-1:0]            current_ch2_o,
  output logic [CUR_W-1:0]            current_ch3_o,
  output logic                        currents_updated_o,
  output logic                        frame_too_long_o
);

  localparam int SB     = SAMPLE_BITS;
  localparam int CNT_W  = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int RAIL_W = SB + $clog2(MAX_FRAME_SAMPLES);
  localparam int ACC_W  = SB + FPU_W;
  localparam int PROD_W = CFG_W + ACC_W;
  localparam int NUM_W  = PROD_W + THOU_W;
  localparam int DVW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // Configuration registers.
  logic [FPU_W-1:0] fpu_q;
  logic [CFG_W-1:0] scale_q;
  logic [CFG_W-1:0] coeff_q;
  logic [CFG_W-1:0] thr_q;

  // Frame tracking and accumulation state.
  logic [SB-1:0]     fmin_q [NCH];
  logic [SB-1:0]     fmax_q [NCH];
  logic [RAIL_W-1:0] rail_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              ovf_q;
  logic [ACC_W-1:0]  min_acc_q [NCH];
  logic [ACC_W-1:0]  max_acc_q [NCH];
  logic [FPU_W-1:0]  fc_q;
  logic [CUR_W-1:0]  held_q [NCH];

  logic [SB-1:0]     fmin_d [NCH];
  logic [SB-1:0]     fmax_d [NCH];
  logic [RAIL_W-1:0] rail_d;
  logic [CNT_W-1:0]  cnt_d;
  logic              ovf_d;
  logic [ACC_W-1:0]  min_acc_d [NCH];
  logic [ACC_W-1:0]  max_acc_d [NCH];
  logic [FPU_W-1:0]  fc_d;
  logic [CUR_W-1:0]  held_d [NCH];

  // Sequencer and result bookkeeping.
  state_e          state_q, state_d;
  logic [CH_W-1:0] ch_q, ch_d;
  logic            upd_q, upd_d;
  logic            ovf_res_q, ovf_res_d;
  logic            out_valid_q, out_valid_d;

  // Datapath registers without reset.
  logic [SB-1:0]     rail_avg_q, rail_avg_d;
  logic [ACC_W-1:0]  hi_q, hi_d;
  logic [ACC_W-1:0]  avg_q, avg_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [NUM_W-1:0]  cur_raw_q, cur_raw_d;
  logic [SB-1:0]     out_rail_q, out_rail_d;
  logic [CUR_W-1:0]  out_cur_q [NCH];
  logic [CUR_W-1:0]  out_cur_d [NCH];
  logic              out_upd_q, out_upd_d;
  logic              out_ovf_q, out_ovf_d;

  // Frame values after taking the current sample set.
  logic [SB-1:0]     samp [NCH];
  logic [SB-1:0]     fmin_n [NCH];
  logic [SB-1:0]     fmax_n [NCH];
  logic [RAIL_W-1:0] rail_n;
  logic [CNT_W-1:0]  cnt_n;
  logic              ovf_n;

  logic [FPU_W-1:0] fc_inc;
  logic [FPU_W-1:0] n_eff;
  logic             upd_now;
  logic             in_acc;
  logic             out_free;

  logic [ACC_W-1:0] lo;
  logic [NUM_W-1:0] num;
  logic [CUR_W-1:0] cur_sat;

  // Shared divider.
  logic             div_start;
  logic [NUM_W-1:0] div_dividend;
  logic [DVW-1:0]   div_divisor;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  ppcm_div #(
    .DW  (NUM_W),
    .DVW (DVW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign samp[0] = sample_ch1_i;
  assign samp[1] = sample_ch2_i;
  assign samp[2] = sample_ch3_i;

  // A frame that already holds the maximum number of sets ignores the rest
  // and only records that it ran long.
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      fmin_n[c] = fmin_q[c];
      fmax_n[c] = fmax_q[c];
    end
    rail_n = rail_q;
    cnt_n  = cnt_q;
    ovf_n  = ovf_q;
    if (cnt_q < CNT_W'(MAX_FRAME_SAMPLES)) begin
      for (int c = 0; c < NCH; c++) begin
        if (samp[c] < fmin_q[c]) begin
          fmin_n[c] = samp[c];
        end
        if (samp[c] > fmax_q[c]) begin
          fmax_n[c] = samp[c];
        end
      end
      rail_n = rail_q + RAIL_W'(sample_rail_i);
      cnt_n  = cnt_q + 1'b1;
    end else begin
      ovf_n = 1'b1;
    end
  end

  // A frames_per_update of zero counts as one.
  assign n_eff   = (fpu_q == '0) ? FPU_W'(1) : fpu_q;
  assign fc_inc  = fc_q + 1'b1;
  assign upd_now = (fc_inc >= n_eff);

  assign lo  = div_quo[ACC_W-1:0];
  assign num = NUM_W'(prod_q) * NUM_W'(THOUSAND);

  // Clamp the quotient to 16 bits, then apply the zero threshold.
  always_comb begin
    cur_sat = (|cur_raw_q[NUM_W-1:CUR_W]) ? {CUR_W{1'b1}} : cur_raw_q[CUR_W-1:0];
    if (cur_sat <= thr_q) begin
      cur_sat = '0;
    end
  end

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    upd_d       = upd_q;
    ovf_res_d   = ovf_res_q;
    out_valid_d = out_valid_q;
    fc_d        = fc_q;
    rail_d      = rail_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    for (int c = 0; c < NCH; c++) begin
      fmin_d[c]    = fmin_q[c];
      fmax_d[c]    = fmax_q[c];
      min_acc_d[c] = min_acc_q[c];
      max_acc_d[c] = max_acc_q[c];
      held_d[c]    = held_q[c];
      out_cur_d[c] = out_cur_q[c];
    end
    rail_avg_d   = rail_avg_q;
    hi_d         = hi_q;
    avg_d        = avg_q;
    prod_d       = prod_q;
    cur_raw_d    = cur_raw_q;
    out_rail_d   = out_rail_q;
    out_upd_d    = out_upd_q;
    out_ovf_d    = out_ovf_q;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (last_in_frame_i) begin
            for (int c = 0; c < NCH; c++) begin
              min_acc_d[c] = min_acc_q[c] + ACC_W'(fmin_n[c]);
              max_acc_d[c] = max_acc_q[c] + ACC_W'(fmax_n[c]);
              fmin_d[c]    = {SB{1'b1}};
              fmax_d[c]    = '0;
            end
            rail_d       = '0;
            cnt_d        = '0;
            ovf_d        = 1'b0;
            fc_d         = upd_now ? '0 : fc_inc;
            upd_d        = upd_now;
            ovf_res_d    = ovf_n;
            div_start    = 1'b1;
            div_dividend = NUM_W'(rail_n);
            div_divisor  = DVW'(cnt_n);
            state_d      = S_RAIL;
          end else begin
            for (int c = 0; c < NCH; c++) begin
              fmin_d[c] = fmin_n[c];
              fmax_d[c] = fmax_n[c];
            end
            rail_d = rail_n;
            cnt_d  = cnt_n;
            ovf_d  = ovf_n;
          end
        end
      end
      S_RAIL: begin
        if (div_done) begin
          rail_avg_d = div_quo[SB-1:0];
          if (upd_q) begin
            ch_d         = '0;
            div_start    = 1'b1;
            div_dividend = NUM_W'(max_acc_q[0]);
            div_divisor  = DVW'(n_eff);
            state_d      = S_HI;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_HI: begin
        if (div_done) begin
          hi_d         = div_quo[ACC_W-1:0];
          div_start    = 1'b1;
          div_dividend = NUM_W'(min_acc_q[ch_q]);
          div_divisor  = DVW'(n_eff);
          state_d      = S_LO;
        end
      end
      S_LO: begin
        if (div_done) begin
          avg_d   = (hi_q > lo) ? (hi_q - lo) : '0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        prod_d  = PROD_W'(scale_q) * PROD_W'(avg_q);
        state_d = S_SCALE;
      end
      S_SCALE: begin
        if (coeff_q == '0) begin
          // No divisor: any nonzero product saturates.
          cur_raw_d = (num != '0) ? {NUM_W{1'b1}} : '0;
          state_d   = S_SAT;
        end else begin
          div_start    = 1'b1;
          div_dividend = num;
          div_divisor  = DVW'(coeff_q);
          state_d      = S_CUR;
        end
      end
      S_CUR: begin
        if (div_done) begin
          cur_raw_d = div_quo;
          state_d   = S_SAT;
        end
      end
      S_SAT: begin
        held_d[ch_q]    = cur_sat;
        min_acc_d[ch_q] = '0;
        max_acc_d[ch_q] = '0;
        if (ch_q == CH_W'(NCH - 1)) begin
          state_d = S_FIN;
        end else begin
          ch_d         = ch_q + 1'b1;
          div_start    = 1'b1;
          div_dividend = NUM_W'(max_acc_q[ch_q + 1'b1]);
          div_divisor  = DVW'(n_eff);
          state_d      = S_HI;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rail_d  = rail_avg_q;
          for (int c = 0; c < NCH; c++) begin
            out_cur_d[c] = held_q[c];
          end
          out_upd_d = upd_q;
          out_ovf_d = ovf_res_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpu_q       <= FPU_RST;
      scale_q     <= SCALE_RST;
      coeff_q     <= COEFF_RST;
      thr_q       <= THR_RST;
      state_q     <= S_IDLE;
      ch_q        <= '0;
      upd_q       <= 1'b0;
      ovf_res_q   <= 1'b0;
      out_valid_q <= 1'b0;
      fc_q        <= '0;
      rail_q      <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      for (int c = 0; c < NCH; c++) begin
        fmin_q[c]    <= {SB{1'b1}};
        fmax_q[c]    <= '0;
        min_acc_q[c] <= '0;
        max_acc_q[c] <= '0;
        held_q[c]    <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FRAMES_PER_UPDATE: fpu_q   <= cfg_data_i[FPU_W-1:0];
          CFG_SCALE_NUMERATOR:   scale_q <= cfg_data_i;
          CFG_COEFF_THOUSANDTHS: coeff_q <= cfg_data_i;
          CFG_ZERO_THRESHOLD:    thr_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
      state_q     <= state_d;
      ch_q        <= ch_d;
      upd_q       <= upd_d;
      ovf_res_q   <= ovf_res_d;
      out_valid_q <= out_valid_d;
      fc_q        <= fc_d;
      rail_q      <= rail_d;
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      for (int c = 0; c < NCH; c++) begin
        fmin_q[c]    <= fmin_d[c];
        fmax_q[c]    <= fmax_d[c];
        min_acc_q[c] <= min_acc_d[c];
        max_acc_q[c] <= max_acc_d[c];
        held_q[c]    <= held_d[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rail_avg_q <= rail_avg_d;
    hi_q       <= hi_d;
    avg_q      <= avg_d;
    prod_q     <= prod_d;
    cur_raw_q  <= cur_raw_d;
    out_rail_q <= out_rail_d;
    out_upd_q  <= out_upd_d;
    out_ovf_q  <= out_ovf_d;
    for (int c = 0; c < NCH; c++) begin
      out_cur_q[c] <= out_cur_d[c];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign rail_average_o     = out_rail_q;
  assign current_ch1_o      = out_cur_q[0];
  assign current_ch2_o      = out_cur_q[1];
  assign current_ch3_o      = out_cur_q[2];
  assign currents_updated_o = out_upd_q;
  assign frame_too_long_o   = out_ovf_q;

`ifndef SYNTHESIS
  // The divider only finishes while the sequencer waits on it.
  a_div_done_waiting : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_RAIL || state_q == S_HI ||
                  state_q == S_LO || state_q == S_CUR))
    else $error("divider finished outside a waiting state");

  // A frame end always starts with the rail division.
  a_frame_end_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_in_frame_i) |=> (state_q == S_RAIL))
    else $error("frame end did not start the rail division");

  // The per-frame set count never passes its saturation point.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_FRAME_SAMPLES))
    else $error("frame set count beyond maximum");

  // A result that reports an update leaves the frame counter cleared.
  a_update_clears_counter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free && upd_q) |=> (fc_q == '0))
    else $error("update reported with frame counter not cleared");
`endif

endmodule : peak_to_peak_current_meter_top

`default_nettype wire
